### rtl/cdd_pkg.sv
// Shared types, constants and calendar helper functions for the day difference block.
package cdd_pkg;

	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int COUNT_W  = 22;
	localparam int DAYNUM_W = 23;
	localparam int DOY_W    = 9;
	localparam int Q_W      = 9;

	typedef logic [DAY_W-1:0]    day_t;
	typedef logic [MONTH_W-1:0]  month_t;
	typedef logic [YEAR_W-1:0]   year_t;
	typedef logic [COUNT_W-1:0]  count_t;
	typedef logic [DAYNUM_W-1:0] daynum_t;
	typedef logic [DOY_W-1:0]    doy_t;
	typedef logic [Q_W-1:0]      quot_t;

	localparam month_t MONTH_JAN    = 4'd1;
	localparam month_t MONTH_FEB    = 4'd2;
	localparam month_t MONTH_DEC    = 4'd12;
	localparam day_t   FEB_LEAP_LEN = 5'd29;
	localparam count_t COUNT_MAX    = {COUNT_W{1'b1}};

	// Stage advance enables, one per pipeline register.
	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
		logic en4;
	} cdd_stage_en_t;

	// Length of a month in a common year.
	function automatic day_t month_len(month_t m);
		day_t len;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd2:                                       len = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// Days in a common year before the first of the month.
	function automatic doy_t days_before(month_t m);
		doy_t n;
		case (m)
			4'd1:    n = 9'd0;
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

	// Divide a 13-bit value by 25 with a reciprocal multiply (exact below 43690).
	function automatic quot_t div25(logic [12:0] x);
		logic [25:0] p;
		p = 26'(x) * 26'd5243;
		return p[25:17];
	endfunction

endpackage

### rtl/cdd_in_if.sv
// Input channel carrying a pair of dates and the include-end flag.
interface cdd_in_if;
	import cdd_pkg::*;

	logic   valid;
	logic   ready;
	day_t   start_day;
	month_t start_month;
	year_t  start_year;
	day_t   end_day;
	month_t end_month;
	year_t  end_year;
	logic   include_end;

	modport source (
		output valid, start_day, start_month, start_year,
		output end_day, end_month, end_year, include_end,
		input  ready
	);
	modport sink (
		input  valid, start_day, start_month, start_year,
		input  end_day, end_month, end_year, include_end,
		output ready
	);
endinterface

### rtl/cdd_out_if.sv
// Output channel carrying the day count and the invalid-date flag.
interface cdd_out_if;
	import cdd_pkg::*;

	logic   valid;
	logic   ready;
	count_t day_count;
	logic   date_invalid;

	modport source (output valid, day_count, date_invalid, input ready);
	modport sink (input valid, day_count, date_invalid, output ready);
endinterface

### rtl/calendar_day_difference.sv
// Top level of the Gregorian day difference pipeline.
// Each transfer on dates carries a start date, an end date and an include-end flag; one
// transfer on days follows with the number of days from start to end (0 when the start
// is not before the end), plus one when include_end is set, saturated at 4194303. A
// month outside 1 to 12, or a day that is 0 or past the month's length, sets
// date_invalid and forces the count to 0. The block is a four-stage pipeline: both
// dates are turned into day numbers in three stages with reciprocal multiplies for the
// century corrections, and the fourth stage forms the difference into the output
// register. A new item is taken every cycle while the days channel is ready;
// throughput is set only by that ready. A stall there holds the output register and
// every full stage with no empty stage between it and the output, while an empty
// stage keeps taking data from the one before it.
module calendar_day_difference (
	input  logic clk,
	input  logic arst_n,
	cdd_in_if.sink    dates,
	cdd_out_if.source days
);
	import cdd_pkg::*;

	cdd_stage_en_t en;
	logic          vld_s1, vld_s2, vld_s3, vld_s4;
	logic          inc_s1, inc_s2, inc_s3;
	daynum_t       start_num, end_num;
	logic          start_ok, end_ok;

	// Advance a stage when it is empty or the stage after it advances
	always_comb begin
		en.en4 = !vld_s4 || days.ready;
		en.en3 = !vld_s3 || en.en4;
		en.en2 = !vld_s2 || en.en3;
		en.en1 = !vld_s1 || en.en2;
	end

	assign dates.ready = en.en1;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (en.en1) vld_s1 <= dates.valid;
			if (en.en2) vld_s2 <= vld_s1;
			if (en.en3) vld_s3 <= vld_s2;
			if (en.en4) vld_s4 <= vld_s3;
		end
	end

	// Carry the include-end flag alongside the conversion stages
	always_ff @(posedge clk) begin
		if (en.en1) inc_s1 <= dates.include_end;
		if (en.en2) inc_s2 <= inc_s1;
		if (en.en3) inc_s3 <= inc_s2;
	end

	cdd_date_conv u_start_conv (
		.clk     (clk),
		.en      (en),
		.day     (dates.start_day),
		.month   (dates.start_month),
		.year    (dates.start_year),
		.day_num (start_num),
		.date_ok (start_ok)
	);

	cdd_date_conv u_end_conv (
		.clk     (clk),
		.en      (en),
		.day     (dates.end_day),
		.month   (dates.end_month),
		.year    (dates.end_year),
		.day_num (end_num),
		.date_ok (end_ok)
	);

	cdd_diff u_diff (
		.clk          (clk),
		.en           (en),
		.start_num    (start_num),
		.end_num      (end_num),
		.start_ok     (start_ok),
		.end_ok       (end_ok),
		.include_end  (inc_s3),
		.day_count    (days.day_count),
		.date_invalid (days.date_invalid)
	);

	assign days.valid = vld_s4;
endmodule

### rtl/cdd_date_conv.sv
// Three-stage conversion of one date into a day number plus a validity check.
module cdd_date_conv (
	input  logic                  clk,
	input  cdd_pkg::cdd_stage_en_t en,
	input  cdd_pkg::day_t         day,
	input  cdd_pkg::month_t       month,
	input  cdd_pkg::year_t        year,
	output cdd_pkg::daynum_t      day_num,
	output logic                  date_ok
);
	import cdd_pkg::*;

	logic [14:0] y_p3, y_p99, y_p399;
	logic [12:0] ceil4;
	quot_t       ceil100, ceil400, quo100;
	daynum_t     y365;
	logic        month_ok;

	logic [12:0] ceil4_s1;
	quot_t       ceil100_s1, ceil400_s1, quo100_s1;
	daynum_t     y365_s1;
	year_t       year_s1;
	month_t      month_s1;
	day_t        day_s1;
	logic        month_ok_s1;

	logic        leap;
	logic [15:0] hundreds;
	day_t        mlen;

	daynum_t     yr_s2;
	logic [9:0]  md_s2;
	logic        ok_s2;

	daynum_t     dn_s3;
	logic        ok_s3;

	// Stage 1: leap-day corrections as ceiling quotients, year over 100, year times 365, month check
	always_comb begin
		y_p3     = {1'b0, year} + 15'd3;
		y_p99    = {1'b0, year} + 15'd99;
		y_p399   = {1'b0, year} + 15'd399;
		ceil4    = y_p3[14:2];
		ceil100  = div25(y_p99[14:2]);
		ceil400  = div25({2'b00, y_p399[14:4]});
		quo100   = div25({1'b0, year[13:2]});
		y365     = DAYNUM_W'(year) * DAYNUM_W'(365);
		month_ok = (month >= MONTH_JAN) && (month <= MONTH_DEC);
	end

	always_ff @(posedge clk) begin
		if (en.en1) begin
			ceil4_s1    <= ceil4;
			ceil100_s1  <= ceil100;
			ceil400_s1  <= ceil400;
			quo100_s1   <= quo100;
			y365_s1     <= y365;
			year_s1     <= year;
			month_s1    <= month;
			day_s1      <= day;
			month_ok_s1 <= month_ok;
		end
	end

	// Stage 2: leap year, day range check, year part and day-of-year part
	always_comb begin
		hundreds = 16'(quo100_s1) * 16'd100;
		leap     = (year_s1[1:0] == 2'b00) &&
		           ((hundreds != 16'(year_s1)) || (quo100_s1[1:0] == 2'b00));
		mlen     = ((month_s1 == MONTH_FEB) && leap) ? FEB_LEAP_LEN : month_len(month_s1);
	end

	always_ff @(posedge clk) begin
		if (en.en2) begin
			yr_s2 <= y365_s1 + DAYNUM_W'(ceil4_s1) - DAYNUM_W'(ceil100_s1)
			         + DAYNUM_W'(ceil400_s1);
			md_s2 <= 10'(days_before(month_s1)) + 10'(leap && (month_s1 > MONTH_FEB))
			         + 10'(day_s1);
			ok_s2 <= month_ok_s1 && (day_s1 != '0) && (day_s1 <= mlen);
		end
	end

	// Stage 3: combine into the day number counted from 1 January of year 0
	always_ff @(posedge clk) begin
		if (en.en3) begin
			dn_s3 <= yr_s2 + DAYNUM_W'(md_s2) - DAYNUM_W'(1);
			ok_s3 <= ok_s2;
		end
	end

	assign day_num = dn_s3;
	assign date_ok = ok_s3;
endmodule

### rtl/cdd_diff.sv
// Final stage: difference of day numbers, include-end adjust and saturation.
module cdd_diff (
	input  logic                  clk,
	input  cdd_pkg::cdd_stage_en_t en,
	input  cdd_pkg::daynum_t      start_num,
	input  cdd_pkg::daynum_t      end_num,
	input  logic                  start_ok,
	input  logic                  end_ok,
	input  logic                  include_end,
	output cdd_pkg::count_t       day_count,
	output logic                  date_invalid
);
	import cdd_pkg::*;

	daynum_t     diff;
	logic [23:0] total;
	logic        bad;
	count_t      count;

	// Clamp negative spans to zero, add the end day, saturate, zero the count for a bad date
	always_comb begin
		bad   = !(start_ok && end_ok);
		diff  = (start_num < end_num) ? (end_num - start_num) : '0;
		total = 24'(diff) + 24'(include_end);
		if (bad) begin
			count = '0;
		end else if (total > 24'(COUNT_MAX)) begin
			count = COUNT_MAX;
		end else begin
			count = total[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en.en4) begin
			day_count    <= count;
			date_invalid <= bad;
		end
	end
endmodule
